[sv/tlte_pkg.sv]
// shared types and constants of the legacy tpm transport engine
package tlte_pkg;

  // input item kinds
  localparam logic [1:0] KIND_RX_BEGIN = 2'd0;
  localparam logic [1:0] KIND_RX_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TX_BEGIN = 2'd2;
  localparam logic [1:0] KIND_TX_BYTE  = 2'd3;

  // result kinds
  localparam logic [1:0] OUT_HOST = 2'd0;
  localparam logic [1:0] OUT_DEV  = 2'd1;
  localparam logic [1:0] OUT_DONE = 2'd2;

  // receive status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_VERSION = 3'd1;
  localparam logic [2:0] ST_VENDOR_ERR  = 3'd2;
  localparam logic [2:0] ST_ERROR_FRAME = 3'd3;
  localparam logic [2:0] ST_UNKNOWN     = 3'd4;
  localparam logic [2:0] ST_SHORT       = 3'd5;

  // frame header bytes
  localparam logic [7:0] HDR_VERSION  = 8'h01;
  localparam logic [7:0] CTL_DATA     = 8'h04;
  localparam logic [7:0] CTL_WTX      = 8'h10;
  localparam logic [7:0] CTL_ABORT    = 8'h18;
  localparam logic [7:0] CTL_ERROR    = 8'h20;
  localparam logic [7:0] CTL_DATA_HDR = 8'h0B;

  // vendor error signature and frame limits
  localparam logic [15:0] VENDOR_SIZE  = 16'h6D00;
  localparam logic [7:0]  VENDOR_MARK  = 8'h80;
  localparam logic [15:0] DATA_SKIP    = 16'd6;
  localparam logic [2:0]  HDR_LAST_POS = 3'd3;
  localparam logic [7:0]  WTX_DEFAULT  = 8'd50;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_DATA
  } rx_phase_t;

  typedef enum logic [2:0] {
    JOB_NONE,
    JOB_HOST_BYTE,
    JOB_DEV_BYTE,
    JOB_DONE,
    JOB_BYTE_DONE,
    JOB_REPLY,
    JOB_SEND_HDR
  } job_op_t;

  // one queued job: the back end expands it into results
  typedef struct packed {
    job_op_t     op;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [15:0] length;
  } job_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] send_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [2:0]  status;
    logic [15:0] received_length;
    logic        last;
  } out_item_t;

endpackage

[sv/tlte_front.sv]
// front end: accepts items, tracks the receive frame and classifies into jobs
module tlte_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_take,
  input  tlte_pkg::in_item_t item,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  output tlte_pkg::job_t    job
);
  import tlte_pkg::*;

  rx_phase_t   phase_r, phase_nxt;
  logic [2:0]  hpos_r, hpos_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [15:0] fsize_r, fsize_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [7:0]  sdb_r, sdb_nxt;
  logic [7:0]  ext_r, ext_nxt;
  logic        badv_r, badv_nxt;
  logic [7:0]  max_ext_r;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hpos_r  <= '0;
      ctrl_r  <= '0;
      fsize_r <= '0;
      seen_r  <= '0;
      sdb_r   <= '0;
      ext_r   <= '0;
      badv_r  <= 1'b0;
    end else if (item_take) begin
      phase_r <= phase_nxt;
      hpos_r  <= hpos_nxt;
      ctrl_r  <= ctrl_nxt;
      fsize_r <= fsize_nxt;
      seen_r  <= seen_nxt;
      sdb_r   <= sdb_nxt;
      ext_r   <= ext_nxt;
      badv_r  <= badv_nxt;
    end
  end

  // wait extension limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_ext_r <= WTX_DEFAULT;
    end else if (cfg_we) begin
      max_ext_r <= cfg_wdata;
    end
  end

  // next state and job classification
  always_comb begin
    logic [7:0]  b;
    logic [15:0] size_full;
    logic        vendor;
    logic        emit;
    logic        fin;
    logic [2:0]  fin_status;
    logic [15:0] fin_len;
    b          = item.data_byte;
    size_full  = {fsize_r[15:8], b};
    vendor     = 1'b0;
    emit       = 1'b0;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_len    = '0;
    phase_nxt  = phase_r;
    hpos_nxt   = hpos_r;
    ctrl_nxt   = ctrl_r;
    fsize_nxt  = fsize_r;
    seen_nxt   = seen_r;
    sdb_nxt    = sdb_r;
    ext_nxt    = ext_r;
    badv_nxt   = badv_r;
    job        = '{op: JOB_NONE, data_byte: b, status: ST_OK, length: '0};

    unique case (item.kind)
      KIND_RX_BEGIN: begin
        phase_nxt = PH_HEADER;
        hpos_nxt  = '0;
        ext_nxt   = '0;
        badv_nxt  = 1'b0;
      end
      KIND_RX_BYTE: begin
        unique case (phase_r)
          PH_HEADER: begin
            if (hpos_r >= HDR_LAST_POS) begin
              // header complete: act on it
              fsize_nxt = size_full;
              hpos_nxt  = '0;
              if (badv_r) begin
                fin        = 1'b1;
                fin_status = ST_BAD_VERSION;
              end else begin
                unique case (ctrl_r)
                  CTL_DATA: begin
                    seen_nxt = '0;
                    sdb_nxt  = '0;
                    if (size_full == '0) begin
                      fin        = 1'b1;
                      fin_status = ST_SHORT;
                    end else begin
                      phase_nxt = PH_DATA;
                    end
                  end
                  CTL_WTX: begin
                    job.op = JOB_REPLY;
                    if (ext_r < max_ext_r) begin
                      ext_nxt       = ext_r + 8'd1;
                      job.data_byte = CTL_WTX;
                    end else begin
                      ext_nxt       = '0;
                      job.data_byte = CTL_ABORT;
                    end
                  end
                  CTL_ABORT: begin
                    fin        = 1'b1;
                    fin_status = ST_OK;
                  end
                  CTL_ERROR: begin
                    fin        = 1'b1;
                    fin_status = ST_ERROR_FRAME;
                  end
                  default: begin
                    fin        = 1'b1;
                    fin_status = ST_UNKNOWN;
                  end
                endcase
              end
            end else begin
              // collect header bytes
              case (hpos_r)
                3'd0:    badv_nxt = (b != HDR_VERSION);
                3'd1:    ctrl_nxt = b;
                default: fsize_nxt = {b, 8'h00};
              endcase
              hpos_nxt = hpos_r + 3'd1;
            end
          end
          PH_DATA: begin
            if (seen_r == 16'd1) sdb_nxt = b;
            vendor   = (fsize_r == VENDOR_SIZE) && (sdb_nxt == VENDOR_MARK);
            emit     = (seen_r >= DATA_SKIP) && !vendor;
            seen_nxt = seen_r + 16'd1;
            if (seen_nxt == fsize_r) begin
              fin = 1'b1;
              if (vendor) begin
                fin_status = ST_VENDOR_ERR;
              end else if (fsize_r < DATA_SKIP) begin
                fin_status = ST_SHORT;
              end else begin
                fin_status = ST_OK;
                fin_len    = fsize_r - DATA_SKIP;
              end
            end
          end
          default: begin
          end
        endcase
        // finishing returns the receiver to idle
        if (fin) begin
          phase_nxt  = PH_IDLE;
          hpos_nxt   = '0;
          job.status = fin_status;
          job.length = fin_len;
        end
        if (emit && fin) begin
          job.op = JOB_BYTE_DONE;
        end else if (emit) begin
          job.op = JOB_HOST_BYTE;
        end else if (fin) begin
          job.op = JOB_DONE;
        end
      end
      KIND_TX_BEGIN: begin
        job.op     = JOB_SEND_HDR;
        job.length = item.send_count;
      end
      default: begin
        job.op = JOB_DEV_BYTE;
      end
    endcase
  end

endmodule

[sv/tlte_jobq.sv]
// job queue between front and back end
module tlte_jobq #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tlte_pkg::job_t push_job,
  input  logic           pop,
  output tlte_pkg::job_t head_job,
  output logic           full,
  output logic           not_empty
);
  import tlte_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

[sv/tlte_back.sv]
// back end: expands queued jobs into result transfers
module tlte_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tlte_pkg::job_t      head_job,
  input  logic                job_avail,
  output logic                job_pop,
  input  logic                out_stall,
  output logic                out_valid,
  output tlte_pkg::out_item_t out_data
);
  import tlte_pkg::*;

  logic [3:0]  step_r;
  logic [3:0]  final_step;
  logic        load;
  logic        out_valid_r;
  out_item_t   out_data_r;
  out_item_t   res;
  logic [15:0] tx_len;

  assign load      = job_avail && (!out_valid_r || !out_stall);
  assign job_pop   = load && (step_r == final_step);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign tx_len    = head_job.length + DATA_SKIP;

  // result for the current step of the head job
  always_comb begin
    res        = '{out_kind: OUT_DEV, out_byte: 8'h00, status: ST_OK,
                   received_length: 16'h0000, last: 1'b0};
    final_step = 4'd0;
    unique case (head_job.op)
      JOB_HOST_BYTE: begin
        res.out_kind = OUT_HOST;
        res.out_byte = head_job.data_byte;
      end
      JOB_DONE: begin
        res.out_kind        = OUT_DONE;
        res.status          = head_job.status;
        res.received_length = head_job.length;
      end
      JOB_BYTE_DONE: begin
        final_step = 4'd1;
        if (step_r == 4'd0) begin
          res.out_kind = OUT_HOST;
          res.out_byte = head_job.data_byte;
        end else begin
          res.out_kind        = OUT_DONE;
          res.status          = head_job.status;
          res.received_length = head_job.length;
        end
      end
      JOB_REPLY: begin
        final_step = 4'd3;
        case (step_r)
          4'd0:    res.out_byte = HDR_VERSION;
          4'd1:    res.out_byte = head_job.data_byte;
          default: res.out_byte = 8'h00;
        endcase
      end
      JOB_SEND_HDR: begin
        final_step = 4'd9;
        case (step_r)
          4'd0:    res.out_byte = HDR_VERSION;
          4'd1:    res.out_byte = CTL_DATA;
          4'd2:    res.out_byte = tx_len[15:8];
          4'd3:    res.out_byte = tx_len[7:0];
          4'd4:    res.out_byte = HDR_VERSION;
          4'd5:    res.out_byte = CTL_DATA_HDR;
          4'd8:    res.out_byte = head_job.length[15:8];
          4'd9:    res.out_byte = head_job.length[7:0];
          default: res.out_byte = 8'h00;
        endcase
      end
      default: begin
        res.out_byte = head_job.data_byte;
      end
    endcase
    res.last = (step_r == final_step);
  end

  // step counter within the head job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (load) begin
      step_r <= job_pop ? 4'd0 : step_r + 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= res;
  end

endmodule

[sv/tpm_legacy_transport_engine_top.sv]
// top level of the legacy tpm byte fifo transport engine
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | in_item_t: kind, data_byte, send_count
//  out_    | output    | out_valid/out_stall | out_item_t: out_kind .. last
//  cfg_    | input     | cfg_valid/cfg_ready | max_wait_extensions, 8 bits
//
// one input item is taken per cycle while the job queue has room; the
// back end drives one result per cycle while out_stall does not hold it, so
// a begin-send expands into ten results and a wait extension reply into four.
// reset is synchronous, active low; the wait extension limit resets to 50.
// in_stall rises only when the job queue is full; out_stall holds the
// output register and, through the queue, backs up to the input.
module tpm_legacy_transport_engine_top #(
  parameter int JOBQ_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tlte_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tlte_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import tlte_pkg::*;

  job_t job;
  job_t head_job;
  logic q_full;
  logic q_not_empty;
  logic q_pop;
  logic item_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign item_take = in_valid && !in_stall;

  // frame tracking and classification
  tlte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_take (item_take),
    .item      (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_wdata (cfg_data),
    .job       (job)
  );

  // job queue
  tlte_jobq #(
    .DEPTH (JOBQ_DEPTH)
  ) u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (item_take && (job.op != JOB_NONE)),
    .push_job  (job),
    .pop       (q_pop),
    .head_job  (head_job),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // result sequencing
  tlte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .job_avail (q_not_empty),
    .job_pop   (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
